/* sv/yawed_box_pair_collide_distance_core_defines.svh */
// Assertion macros for the yawed box pair collide/distance core.
// Taken in by the top level; no other dependencies.
`ifndef YAWED_BOX_PAIR_COLLIDE_DISTANCE_CORE_DEFINES_SVH
`define YAWED_BOX_PAIR_COLLIDE_DISTANCE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define YBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// antecedent implies consequent in the next cycle
`define YBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define YBP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define YBP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/ybpcd_pkg.sv */
// Package for the yawed box pair collide/distance core: payload types,
// fixed widths and the sine table generator. No dependencies.
`timescale 1ns / 1ps

package ybpcd_pkg;

    localparam int COORD_W   = 32;
    localparam int HALF_W    = 31;
    localparam int YAW_W     = 16;
    localparam int TOL_W     = 16;
    localparam int TRIG_BITS = 28;
    localparam int TRIG_W    = 30;   // signed sin/cos, Q28
    localparam int COEF_W    = 30;   // unsigned projection coefficients
    localparam int ROM_W     = 29;   // sine magnitude, up to 1.0 in Q28
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int ROOT_W    = 34;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 3;
    localparam int SQ_STAGES = ROOT_W / 2;

    localparam logic [0:0] REG_TOL = 1'b0;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [7:0]  TAYLOR_DEN [6] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

    typedef struct packed {
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
        logic signed [COORD_W-1:0] offset_z;
        logic [HALF_W-1:0]         first_half_x;
        logic [HALF_W-1:0]         first_half_y;
        logic [HALF_W-1:0]         first_half_z;
        logic [YAW_W-1:0]          first_yaw;
        logic [HALF_W-1:0]         second_half_x;
        logic [HALF_W-1:0]         second_half_y;
        logic [HALF_W-1:0]         second_half_z;
        logic [YAW_W-1:0]          second_yaw;
    } item_t;

    typedef struct packed {
        logic               collides;
        logic [COORD_W-1:0] separation;
    } res_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } sq_t;

    // One quarter-wave table entry: Taylor series in Q30, rounded to Q28.
    function automatic logic [ROM_W-1:0] sine_entry(input logic [63:0] j, input int qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = (j * HALF_PI_Q30) >> qbits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int i = 0; i < 6; i++)
        begin
            t = Q30_ONE - ((x2 * t) >> 30) / 64'(TAYLOR_DEN[i]);
        end
        t = (x * t) >> 30;
        if (t > Q30_ONE)
        begin
            t = Q30_ONE;
        end
        t = (t + 64'd2) >> 2;
        return t[ROM_W-1:0];
    endfunction

endpackage

/* sv/yawed_box_pair_collide_distance_core.sv */
// Top level of the yawed box pair collide/distance core.
// Depends on ybpcd_pkg and yawed_box_pair_collide_distance_core_defines.svh.
`timescale 1ns / 1ps
`include "yawed_box_pair_collide_distance_core_defines.svh"

// Usage
// - item channel (item_valid/item_ready/item): one box pair per transfer.
// - result channel (result_valid/result_ready/result): collides flag and
//   floor distance, one transfer per item, in input order.
// - APB port: register 0 at byte address 0 is contact_tolerance (16 bits,
//   Q16.16 LSBs). Write it only while the core is empty. pready is tied high.
// Timing
// - 27 register stages from an item's transfer to its result. One item per
//   cycle sustained while result_ready stays high.
// - Stages: sine lookup, trig and offset products, dot sums, radius
//   products, radius sums, gap/test, max gap, squares, sum, 17 square root
//   stages (two root bits each), output register.
// - Each stage holds only while its successor is full and stalled, so
//   bubbles close up under a result stall and input keeps flowing until the
//   whole pipe is full.
// Reset
// - rst_n clears all stage valids and sets contact_tolerance to 0.
module yawed_box_pair_collide_distance_core
    import ybpcd_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_ready,
    output res_t              result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int QB      = SINE_TABLE_BITS - 2;
    localparam int QUARTER = 1 << QB;
    localparam int TB      = SINE_TABLE_BITS;

    localparam int ST_A   = 0;
    localparam int ST_B   = 1;
    localparam int ST_C   = 2;
    localparam int ST_D   = 3;
    localparam int ST_E   = 4;
    localparam int ST_F   = 5;
    localparam int ST_G   = 6;
    localparam int ST_H   = 7;
    localparam int ST_I   = 8;
    localparam int ST_SQ  = 9;
    localparam int ST_OUT = ST_SQ + SQ_STAGES;
    localparam int NST    = ST_OUT + 1;

    // ---------------- configuration ----------------
    logic [TOL_W-1:0] tol_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == REG_TOL) ? APB_DW'(tol_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2:2] == REG_TOL))
        begin
            tol_reg <= pwdata[TOL_W-1:0];
        end
    end

    // ---------------- stage flow control ----------------
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    assign en[NST-1] = !v_reg[NST-1] || result_ready;
    genvar gs;
    generate
        for (gs = 0; gs < NST - 1; gs++)
        begin : g_en
            assign en[gs] = !v_reg[gs] || en[gs+1];
        end
    endgenerate

    assign item_ready   = en[ST_A];
    assign result_valid = v_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= item_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // ---------------- quarter-wave sine table ----------------
    logic [ROM_W-1:0] rom [QUARTER+1];
    genvar gr;
    generate
        for (gr = 0; gr <= QUARTER; gr++)
        begin : g_rom
            assign rom[gr] = sine_entry(64'(gr), QB);
        end
    endgenerate

    // lookups: sin1, cos1, sin2, cos2
    logic [TB-1:0]            tk [4];
    logic signed [TRIG_W-1:0] tv [4];
    logic [1:0]               tq;
    logic [QB:0]              tidx;
    logic [ROM_W-1:0]         tmag;

    always_comb
    begin
        tk[0] = item.first_yaw[YAW_W-1 -: TB];
        tk[1] = tk[0] + TB'(QUARTER);
        tk[2] = item.second_yaw[YAW_W-1 -: TB];
        tk[3] = tk[2] + TB'(QUARTER);
        tq    = '0;
        tidx  = '0;
        tmag  = '0;
        for (int i = 0; i < 4; i++)
        begin
            tq    = tk[i][TB-1:TB-2];
            tidx  = tq[0] ? ((QB+1)'(QUARTER) - {1'b0, tk[i][QB-1:0]}) : {1'b0, tk[i][QB-1:0]};
            tmag  = rom[tidx];
            tv[i] = tq[1] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
        end
    end

    // ---------------- stage A: trig values, vertical terms ----------------
    logic signed [TRIG_W-1:0]  a_s1_reg, a_c1_reg, a_s2_reg, a_c2_reg;
    logic signed [COORD_W-1:0] a_dx_reg, a_dz_reg;
    logic [HALF_W-1:0]         a_h1x_reg, a_h1z_reg, a_h2x_reg, a_h2z_reg;
    logic [COORD_W-1:0]        a_ady_reg, a_hsum_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_A])
        begin
            a_s1_reg   <= tv[0];
            a_c1_reg   <= tv[1];
            a_s2_reg   <= tv[2];
            a_c2_reg   <= tv[3];
            a_dx_reg   <= item.offset_x;
            a_dz_reg   <= item.offset_z;
            a_h1x_reg  <= item.first_half_x;
            a_h1z_reg  <= item.first_half_z;
            a_h2x_reg  <= item.second_half_x;
            a_h2z_reg  <= item.second_half_z;
            a_ady_reg  <= item.offset_y[COORD_W-1] ? COORD_W'(-item.offset_y)
                                                   : COORD_W'(item.offset_y);
            a_hsum_reg <= COORD_W'(item.first_half_y) + COORD_W'(item.second_half_y);
        end
    end

    // ---------------- stage B: products ----------------
    logic signed [2*TRIG_W-1:0]       b_c1c1_reg, b_s1s1_reg, b_c2c2_reg, b_s2s2_reg;
    logic signed [2*TRIG_W-1:0]       b_c1c2_reg, b_s1s2_reg, b_s1c2_reg, b_c1s2_reg;
    logic signed [COORD_W+TRIG_W-1:0] b_dxc1_reg, b_dzs1_reg, b_dxs1_reg, b_dzc1_reg;
    logic signed [COORD_W+TRIG_W-1:0] b_dxc2_reg, b_dzs2_reg, b_dxs2_reg, b_dzc2_reg;
    logic [HALF_W-1:0]                b_h1x_reg, b_h1z_reg, b_h2x_reg, b_h2z_reg;
    logic                             b_vhit_reg;
    logic [COORD_W-1:0]               b_gy_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_B])
        begin
            b_c1c1_reg <= a_c1_reg * a_c1_reg;
            b_s1s1_reg <= a_s1_reg * a_s1_reg;
            b_c2c2_reg <= a_c2_reg * a_c2_reg;
            b_s2s2_reg <= a_s2_reg * a_s2_reg;
            b_c1c2_reg <= a_c1_reg * a_c2_reg;
            b_s1s2_reg <= a_s1_reg * a_s2_reg;
            b_s1c2_reg <= a_s1_reg * a_c2_reg;
            b_c1s2_reg <= a_c1_reg * a_s2_reg;
            b_dxc1_reg <= a_dx_reg * a_c1_reg;
            b_dzs1_reg <= a_dz_reg * a_s1_reg;
            b_dxs1_reg <= a_dx_reg * a_s1_reg;
            b_dzc1_reg <= a_dz_reg * a_c1_reg;
            b_dxc2_reg <= a_dx_reg * a_c2_reg;
            b_dzs2_reg <= a_dz_reg * a_s2_reg;
            b_dxs2_reg <= a_dx_reg * a_s2_reg;
            b_dzc2_reg <= a_dz_reg * a_c2_reg;
            b_h1x_reg  <= a_h1x_reg;
            b_h1z_reg  <= a_h1z_reg;
            b_h2x_reg  <= a_h2x_reg;
            b_h2z_reg  <= a_h2z_reg;
            b_vhit_reg <= a_ady_reg < a_hsum_reg;
            b_gy_reg   <= (a_ady_reg > a_hsum_reg) ? (a_ady_reg - a_hsum_reg) : '0;
        end
    end

    // ---------------- stage C: dot sums ----------------
    localparam int TS_W = 2 * TRIG_W + 1;
    localparam int DS_W = COORD_W + TRIG_W + 1;

    logic signed [TS_W-1:0] c_sn1, c_sn2, c_sp, c_sq;
    logic [TS_W-1:0]        c_mp, c_mq;
    logic signed [DS_W-1:0] c_e [4];
    logic [DS_W-1:0]        c_d [4];

    always_comb
    begin
        c_sn1 = TS_W'(b_c1c1_reg) + TS_W'(b_s1s1_reg);
        c_sn2 = TS_W'(b_c2c2_reg) + TS_W'(b_s2s2_reg);
        c_sp  = TS_W'(b_c1c2_reg) + TS_W'(b_s1s2_reg);
        c_sq  = TS_W'(b_s1c2_reg) - TS_W'(b_c1s2_reg);
        c_mp  = c_sp[TS_W-1] ? TS_W'(-c_sp) : TS_W'(c_sp);
        c_mq  = c_sq[TS_W-1] ? TS_W'(-c_sq) : TS_W'(c_sq);
        c_e[0] = DS_W'(b_dxc1_reg) + DS_W'(b_dzs1_reg);
        c_e[1] = DS_W'(b_dzc1_reg) - DS_W'(b_dxs1_reg);
        c_e[2] = DS_W'(b_dxc2_reg) + DS_W'(b_dzs2_reg);
        c_e[3] = DS_W'(b_dzc2_reg) - DS_W'(b_dxs2_reg);
        for (int i = 0; i < 4; i++)
        begin
            c_d[i] = c_e[i][DS_W-1] ? DS_W'(-c_e[i]) : DS_W'(c_e[i]);
        end
    end

    logic [COEF_W-1:0]  c_n1_reg, c_n2_reg, c_p_reg, c_q_reg;
    logic [DS_W-1:0]    c_d_reg [4];
    logic [HALF_W-1:0]  c_h1x_reg, c_h1z_reg, c_h2x_reg, c_h2z_reg;
    logic               c_vhit_reg;
    logic [COORD_W-1:0] c_gy_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_C])
        begin
            c_n1_reg   <= c_sn1[TRIG_BITS+COEF_W-1:TRIG_BITS];
            c_n2_reg   <= c_sn2[TRIG_BITS+COEF_W-1:TRIG_BITS];
            c_p_reg    <= c_mp[TRIG_BITS+COEF_W-1:TRIG_BITS];
            c_q_reg    <= c_mq[TRIG_BITS+COEF_W-1:TRIG_BITS];
            c_d_reg    <= c_d;
            c_h1x_reg  <= b_h1x_reg;
            c_h1z_reg  <= b_h1z_reg;
            c_h2x_reg  <= b_h2x_reg;
            c_h2z_reg  <= b_h2z_reg;
            c_vhit_reg <= b_vhit_reg;
            c_gy_reg   <= b_gy_reg;
        end
    end

    // ---------------- stage D: radius products ----------------
    localparam int RP_W = HALF_W + COEF_W;

    logic [RP_W-1:0]    d_t_reg [4][3];
    logic [DS_W-1:0]    d_d_reg [4];
    logic               d_vhit_reg;
    logic [COORD_W-1:0] d_gy_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_D])
        begin
            // first box x axis
            d_t_reg[0][0] <= c_h1x_reg * c_n1_reg;
            d_t_reg[0][1] <= c_h2x_reg * c_p_reg;
            d_t_reg[0][2] <= c_h2z_reg * c_q_reg;
            // first box z axis
            d_t_reg[1][0] <= c_h1z_reg * c_n1_reg;
            d_t_reg[1][1] <= c_h2x_reg * c_q_reg;
            d_t_reg[1][2] <= c_h2z_reg * c_p_reg;
            // second box x axis
            d_t_reg[2][0] <= c_h1x_reg * c_p_reg;
            d_t_reg[2][1] <= c_h1z_reg * c_q_reg;
            d_t_reg[2][2] <= c_h2x_reg * c_n2_reg;
            // second box z axis
            d_t_reg[3][0] <= c_h1x_reg * c_q_reg;
            d_t_reg[3][1] <= c_h1z_reg * c_p_reg;
            d_t_reg[3][2] <= c_h2z_reg * c_n2_reg;
            d_d_reg    <= c_d_reg;
            d_vhit_reg <= c_vhit_reg;
            d_gy_reg   <= c_gy_reg;
        end
    end

    // ---------------- stage E: radius sums ----------------
    localparam int R_W = RP_W + 2;

    logic [R_W-1:0]     e_r_reg [4];
    logic [DS_W-1:0]    e_d_reg [4];
    logic               e_vhit_reg;
    logic [COORD_W-1:0] e_gy_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_E])
        begin
            for (int i = 0; i < 4; i++)
            begin
                e_r_reg[i] <= R_W'(d_t_reg[i][0]) + R_W'(d_t_reg[i][1]) + R_W'(d_t_reg[i][2]);
            end
            e_d_reg    <= d_d_reg;
            e_vhit_reg <= d_vhit_reg;
            e_gy_reg   <= d_gy_reg;
        end
    end

    // ---------------- stage F: gaps and axis tests ----------------
    localparam int G_W = 64;

    logic signed [G_W-1:0] f_gap_reg [4];
    logic [3:0]            f_ok_reg;
    logic                  f_vhit_reg;
    logic [COORD_W-1:0]    f_gy_reg;
    logic [G_W-1:0]        f_tol;

    assign f_tol = G_W'(tol_reg) << TRIG_BITS;

    always_ff @(posedge clk)
    begin
        if (en[ST_F])
        begin
            for (int i = 0; i < 4; i++)
            begin
                f_gap_reg[i] <= $signed(G_W'(e_d_reg[i])) - $signed(G_W'(e_r_reg[i]));
                f_ok_reg[i]  <= G_W'(e_d_reg[i]) <= (G_W'(e_r_reg[i]) + f_tol);
            end
            f_vhit_reg <= e_vhit_reg;
            f_gy_reg   <= e_gy_reg;
        end
    end

    // ---------------- stage G: largest gap ----------------
    logic signed [G_W-1:0] g_max;

    always_comb
    begin
        g_max = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (f_gap_reg[i] > g_max)
            begin
                g_max = f_gap_reg[i];
            end
        end
    end

    logic               g_hit_reg, g_sat_reg;
    logic [COORD_W-1:0] g_gx_reg, g_gy_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_G])
        begin
            g_hit_reg <= f_vhit_reg && (&f_ok_reg);
            g_sat_reg <= |g_max[G_W-2:TRIG_BITS+COORD_W];
            g_gx_reg  <= g_max[TRIG_BITS+COORD_W-1:TRIG_BITS];
            g_gy_reg  <= f_gy_reg;
        end
    end

    // ---------------- stage H: squares ----------------
    logic [2*COORD_W-1:0] h_gx2_reg, h_gy2_reg;
    logic                 h_hit_reg, h_sat_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_H])
        begin
            h_gx2_reg <= g_gx_reg * g_gx_reg;
            h_gy2_reg <= g_gy_reg * g_gy_reg;
            h_hit_reg <= g_hit_reg;
            h_sat_reg <= g_sat_reg;
        end
    end

    // ---------------- stage I: sum of squares ----------------
    logic [RAD_W-1:0] i_rad_reg;
    logic             i_hit_reg, i_sat_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_I])
        begin
            i_rad_reg <= RAD_W'(h_gx2_reg) + RAD_W'(h_gy2_reg);
            i_hit_reg <= h_hit_reg;
            i_sat_reg <= h_sat_reg;
        end
    end

    // ---------------- square root, two bits per stage ----------------
    function automatic sq_t sqrt_two(input sq_t s);
        sq_t              r;
        logic [REM_W-1:0] trial;
        r = s;
        for (int i = 0; i < 2; i++)
        begin
            r.rem = {r.rem[REM_W-3:0], r.rad[RAD_W-1:RAD_W-2]};
            r.rad = r.rad << 2;
            trial = REM_W'({r.root, 2'b01});
            if (r.rem >= trial)
            begin
                r.rem  = r.rem - trial;
                r.root = {r.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                r.root = {r.root[ROOT_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    sq_t  sq_reg     [SQ_STAGES];
    logic sq_hit_reg [SQ_STAGES];
    logic sq_sat_reg [SQ_STAGES];
    sq_t  sq_init;

    assign sq_init = '{rem: '0, root: '0, rad: i_rad_reg};

    genvar gq;
    generate
        for (gq = 0; gq < SQ_STAGES; gq++)
        begin : g_sqrt
            if (gq == 0)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (en[ST_SQ])
                    begin
                        sq_reg[gq]     <= sqrt_two(sq_init);
                        sq_hit_reg[gq] <= i_hit_reg;
                        sq_sat_reg[gq] <= i_sat_reg;
                    end
                end
            end
            else
            begin : g_next
                always_ff @(posedge clk)
                begin
                    if (en[ST_SQ+gq])
                    begin
                        sq_reg[gq]     <= sqrt_two(sq_reg[gq-1]);
                        sq_hit_reg[gq] <= sq_hit_reg[gq-1];
                        sq_sat_reg[gq] <= sq_sat_reg[gq-1];
                    end
                end
            end
        end
    endgenerate

    // ---------------- output register ----------------
    res_t out_next;
    res_t out_reg;

    always_comb
    begin
        out_next.collides = sq_hit_reg[SQ_STAGES-1];
        if (sq_sat_reg[SQ_STAGES-1] || (|sq_reg[SQ_STAGES-1].root[ROOT_W-1:COORD_W]))
        begin
            out_next.separation = '1;
        end
        else
        begin
            out_next.separation = sq_reg[SQ_STAGES-1].root[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

    // ---------------- assertions ----------------
    // a colliding pair can only be apart by the tolerance slack
    `YBP_ASSERT_IMP(a_hit_within_tol, clk, rst_n, result_valid && result.collides, result.separation <= COORD_W'(tol_reg))
    // vertical overlap means no vertical gap
    `YBP_ASSERT_IMP(a_vert_gap, clk, rst_n, v_reg[ST_C] && c_vhit_reg, c_gy_reg == '0)
    // final root remainder never exceeds twice the root
    `YBP_ASSERT_IMP(a_sqrt_rem, clk, rst_n, v_reg[ST_OUT-1], sq_reg[SQ_STAGES-1].rem <= (REM_W'(sq_reg[SQ_STAGES-1].root) << 1))

endmodule

/* bench/box_pair_contact_checker.sv */
// Checker for the yawed box pair collide/distance core: watches the item,
// result and APB channels, predicts each result and compares it.
// Depends on ybpcd_pkg.
`timescale 1ns / 1ps

module box_pair_contact_checker
    import ybpcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  item_t             item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  res_t              result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    output int                errors,
    output int                pending
);

    localparam int TBL_BITS = 10;
    localparam int QTR      = 1 << (TBL_BITS - 2);

    logic [TOL_W-1:0] tolerance;
    res_t             expected_contacts[$];

    assign pending = expected_contacts.size();

    // Q30 sine of j table steps within the first quadrant
    function automatic logic [63:0] quadrant_sine(input logic [63:0] j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x = (j * HALF_PI_Q30) / QTR;
        x2 = (x * x) >> 30;
        t = Q30_ONE;
        for (int i = 0; i < 6; i++)
        begin
            t = Q30_ONE - ((x2 * t) >> 30) / 64'(TAYLOR_DEN[i]);
        end
        t = (x * t) >> 30;
        if (t > Q30_ONE)
        begin
            t = Q30_ONE;
        end
        return t;
    endfunction

    // signed Q28 sine of table index k
    function automatic longint yaw_sine(input int unsigned k);
        int unsigned kk;
        int unsigned q;
        int unsigned j;
        logic [63:0] m;
        kk = k % (1 << TBL_BITS);
        q = kk / QTR;
        j = kk % QTR;
        m = q[0] ? quadrant_sine(64'(QTR - j)) : quadrant_sine(64'(j));
        m = (m + 64'd2) >> 2;
        return q[1] ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic res_t predict_contact(input item_t it, input logic [TOL_W-1:0] tol_reg);
        int unsigned k1;
        int unsigned k2;
        longint s1, c1, s2, c2;
        longint ax[4];
        longint az[4];
        longint dx, dz;
        longint unsigned h1x, h1z, h2x, h2z, ady, hsum, d, r, tol, gxz, gy, root;
        longint gap, max_gap;
        logic [127:0] norm;
        logic [127:0] cand;
        logic hit;
        res_t rs;
        k1 = it.first_yaw >> (YAW_W - TBL_BITS);
        k2 = it.second_yaw >> (YAW_W - TBL_BITS);
        s1 = yaw_sine(k1);
        c1 = yaw_sine(k1 + QTR);
        s2 = yaw_sine(k2);
        c2 = yaw_sine(k2 + QTR);
        ax[0] = c1;  az[0] = s1;
        ax[1] = -s1; az[1] = c1;
        ax[2] = c2;  az[2] = s2;
        ax[3] = -s2; az[3] = c2;
        dx = longint'(it.offset_x);
        dz = longint'(it.offset_z);
        h1x = longint'({33'b0, it.first_half_x});
        h1z = longint'({33'b0, it.first_half_z});
        h2x = longint'({33'b0, it.second_half_x});
        h2z = longint'({33'b0, it.second_half_z});
        ady = magnitude(longint'(it.offset_y));
        hsum = longint'({33'b0, it.first_half_y}) + longint'({33'b0, it.second_half_y});
        tol = longint'({48'b0, tol_reg}) << TRIG_BITS;
        hit = ady < hsum;
        max_gap = 0;
        for (int i = 0; i < 4; i++)
        begin
            d = magnitude(dx * ax[i] + dz * az[i]);
            r = h1x * (magnitude(c1 * ax[i] + s1 * az[i]) >> TRIG_BITS)
              + h1z * (magnitude(-s1 * ax[i] + c1 * az[i]) >> TRIG_BITS)
              + h2x * (magnitude(c2 * ax[i] + s2 * az[i]) >> TRIG_BITS)
              + h2z * (magnitude(-s2 * ax[i] + c2 * az[i]) >> TRIG_BITS);
            gap = longint'(d) - longint'(r);
            if (d > r + tol)
            begin
                hit = 1'b0;
            end
            if (gap > max_gap)
            begin
                max_gap = gap;
            end
        end
        gxz = longint'(max_gap) >> TRIG_BITS;
        gy = ady > hsum ? ady - hsum : 0;
        norm = 128'(gxz) * 128'(gxz) + 128'(gy) * 128'(gy);
        root = 0;
        for (int b = 52; b >= 0; b--)
        begin
            cand = 128'(root | (64'd1 << b));
            if (cand * cand <= norm)
            begin
                root = cand[63:0];
            end
        end
        rs.collides = hit;
        rs.separation = root > 64'hFFFF_FFFF ? '1 : root[COORD_W-1:0];
        return rs;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            tolerance <= '0;
            errors = 0;
            expected_contacts.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == APB_AW'(0))
            begin
                tolerance <= pwdata[TOL_W-1:0];
            end
            if (item_valid && item_ready)
            begin
                expected_contacts.push_back(predict_contact(item, tolerance));
            end
            if (result_valid && result_ready)
            begin
                if (expected_contacts.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'(result), 64'd0);
                end
                else
                begin
                    want = expected_contacts.pop_front();
                    if (result.collides !== want.collides)
                    begin
                        report_mismatch("collides", 64'(result.collides), 64'(want.collides));
                    end
                    if (result.separation !== want.separation)
                    begin
                        report_mismatch("separation", 64'(result.separation),
                                        64'(want.separation));
                    end
                end
            end
        end
    end

endmodule

/* bench/tb_top.sv */
// Testbench top for the yawed box pair collide/distance core: clock, reset,
// stimulus and verdict. Depends on ybpcd_pkg and box_pair_contact_checker.
`timescale 1ns / 1ps

module tb_top;
    import ybpcd_pkg::*;

    localparam int LATENCY   = 27;     // pipe depth from the core's header
    localparam int MAX_CYCLE = 200000; // watchdog bound; the slow run sends 900 random pairs with gaps and stalls

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    item_t             item = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    res_t              result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                errors;
    int                pending;
    int                cycle = 0;
    bit                allow_idle = 1'b1;
    int                ready_hold = 0;

    always #2 clk = ~clk;

    yawed_box_pair_collide_distance_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    box_pair_contact_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE)
        begin
            $display("FAIL yawed_box_pair_collide_distance_core");
            $finish;
        end
    end

    // Result side back-pressure: random stall bursts,
    // switched off for the final stretch.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            result_ready <= 1'b0;
        end
        else if (allow_idle && rst_n && $urandom_range(0, 3) == 0)
        begin
            ready_hold <= $urandom_range(0, 2);
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // One APB write: setup phase then access phase.
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Stop sending right after the last transfer and wait for every result.
    task automatic drain_pipe();
        item_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Wait for the pipe to drain, then retune the tolerance.
    task automatic retune(input logic [APB_DW-1:0] data);
        drain_pipe();
        write_reg(APB_AW'(0), data);
    endtask

    // Present one pair; valid stays up across back-to-back transfers.
    task automatic send_pair(input item_t it);
        if (allow_idle && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    function automatic item_t pair_of(input int o_x, input int o_y, input int o_z,
                                      input int unsigned h, input logic [15:0] y1,
                                      input logic [15:0] y2);
        item_t it;
        it.offset_x = o_x;
        it.offset_y = o_y;
        it.offset_z = o_z;
        it.first_half_x = HALF_W'(h);
        it.first_half_y = HALF_W'(h);
        it.first_half_z = HALF_W'(h);
        it.second_half_x = HALF_W'(h);
        it.second_half_y = HALF_W'(h);
        it.second_half_z = HALF_W'(h);
        it.first_yaw = y1;
        it.second_yaw = y2;
        return it;
    endfunction

    // Mostly nearby pairs so both hit and miss occur; some over the full range.
    function automatic item_t random_pair();
        item_t        it;
        logic [319:0] noise;
        int unsigned  span;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom};
        it = item_t'(noise[$bits(item_t)-1:0]);
        if ($urandom_range(0, 4) != 0)
        begin
            span = 1 << $urandom_range(8, 24);
            it.offset_x = int'($urandom_range(0, 2 * span)) - int'(span);
            it.offset_y = int'($urandom_range(0, 2 * span)) - int'(span);
            it.offset_z = int'($urandom_range(0, 2 * span)) - int'(span);
            it.first_half_x = HALF_W'($urandom_range(0, span));
            it.first_half_y = HALF_W'($urandom_range(0, span));
            it.first_half_z = HALF_W'($urandom_range(0, span));
            it.second_half_x = HALF_W'($urandom_range(0, span));
            it.second_half_y = HALF_W'($urandom_range(0, span));
            it.second_half_z = HALF_W'($urandom_range(0, span));
        end
        return it;
    endfunction

    initial
    begin
        item_t it;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero pair, flat boxes, axis-aligned and quarter-turn yaws,
        // table step edges, extreme offsets and halves.
        send_pair(pair_of(0, 0, 0, 0, 16'd0, 16'd0));
        send_pair(pair_of(0, 0, 0, 32'h0001_0000, 16'd0, 16'd0));
        it = pair_of(0, 0, 0, 32'h0001_0000, 16'd0, 16'd0);
        it.first_half_y = '0;
        it.second_half_y = '0;
        send_pair(it);
        send_pair(pair_of(32'h0002_0000, 0, 0, 32'h0001_0000, 16'd0, 16'd0));
        send_pair(pair_of(32'h0002_0001, 0, 0, 32'h0001_0000, 16'd16384, 16'd32768));
        send_pair(pair_of(0, 32'h0002_0000, 0, 32'h0001_0000, 16'd49152, 16'd8192));
        send_pair(pair_of(32'h0001_8000, 0, 32'h0001_8000, 32'h0001_0000, 16'd63, 16'd64));
        send_pair(pair_of(-32'sd5, 3, 7, 4, 16'd65535, 16'd8191));
        send_pair(pair_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 16'd0, 16'd0));
        send_pair(pair_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 16'd8192,
                          16'd40960));
        send_pair(pair_of(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd24576,
                          16'd57344));
        send_pair(pair_of(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          16'hFFFF, 16'h0040));
        send_pair(pair_of(-1, -1, -1, 32'h7FFF_FFFF, 16'h8000, 16'h4000));

        // Tolerance at its top: touching pairs should now collide.
        retune(32'hFFFF_FFFF);
        send_pair(pair_of(32'h0002_0000, 0, 0, 32'h0001_0000, 16'd0, 16'd0));
        send_pair(pair_of(32'h0003_0000, 0, 0, 32'h0001_0000, 16'd0, 16'd0));
        send_pair(pair_of(32'h0001_8000, 0, 32'h0001_8000, 32'h0001_0000, 16'd8192, 16'd0));
        drain_pipe();
        write_reg(APB_AW'(4), 32'h0000_1234); // undecoded address, no effect
        send_pair(pair_of(32'h0002_FFFF, 0, 0, 32'h0001_0000, 16'd0, 16'd0));

        // Random phases, each under a fresh tolerance; the drain before each
        // write doubles as the sender pausing on an empty pipe.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: retune(32'd0);
                1: retune(32'd1);
                2: retune(32'h0000_FFFF);
                default: retune($urandom);
            endcase
            if (ph == 5)
            begin
                allow_idle = 1'b0;
            end
            repeat (150) send_pair(random_pair());
        end

        drain_pipe();
        if (errors == 0)
        begin
            $display("PASS yawed_box_pair_collide_distance_core");
        end
        else
        begin
            $display("FAIL yawed_box_pair_collide_distance_core");
        end
        $finish;
    end

endmodule

/* yawed_box_pair_collide_distance_core.f */
+incdir+sv
sv/ybpcd_pkg.sv
sv/yawed_box_pair_collide_distance_core.sv
bench/box_pair_contact_checker.sv
bench/tb_top.sv
